/* hw/rtl/dib_pkg.sv */
// Package: opcodes, widths and shared conversion functions for the int32 bitwise ALU.
package dib_pkg;

  localparam int unsigned DBL_W   = 64;
  localparam int unsigned OP_W    = 3;
  localparam int unsigned INT_W   = 32;
  localparam int unsigned EXP_W   = 11;
  localparam int unsigned MANT_W  = 52;
  localparam int unsigned EXP_BIAS = 1023;

  typedef enum logic [OP_W-1:0] {
    OP_AND = 3'd0,
    OP_OR  = 3'd1,
    OP_XOR = 3'd2,
    OP_NOT = 3'd3,
    OP_SHL = 3'd4,
    OP_SAR = 3'd5,
    OP_SHR = 3'd6,
    OP_NOP = 3'd7
  } op_t;

  // ToUint32 of a binary64 bit pattern
  function automatic logic [INT_W-1:0] to_u32(input logic [DBL_W-1:0] bits);
    logic [EXP_W-1:0]  e;
    logic [MANT_W:0]   m;
    logic [INT_W-1:0]  v;
    logic [11:0]       sh;
    e = bits[62:52];
    m = {1'b1, bits[MANT_W-1:0]};
    v = '0;
    if (e == 11'h7FF || e < 11'd1023) begin
      v = '0;
    end else if (e >= 11'd1075) begin
      sh = {1'b0, e} - 12'd1075;
      if (sh >= 12'd32) v = '0;
      else v = m[INT_W-1:0] << sh[4:0];
    end else begin
      sh = 12'd1075 - {1'b0, e};
      v = INT_W'(m >> sh[5:0]);
    end
    if (bits[63]) v = INT_W'(0) - v;
    return v;
  endfunction

  // exact binary64 bits of a 32-bit integer, signed or unsigned; zero is +0
  function automatic logic [DBL_W-1:0] to_dbl(input logic [INT_W-1:0] r,
                                               input logic uns);
    logic             neg;
    logic [INT_W-1:0] mag;
    logic [INT_W-1:0] nm;
    logic [4:0]       msb;
    neg = ~uns & r[INT_W-1];
    mag = neg ? (INT_W'(0) - r) : r;
    msb = '0;
    for (int i = 0; i < INT_W; i++) begin
      if (mag[i]) msb = 5'(i);
    end
    nm = mag << (5'd31 - msb);
    if (mag == '0) return '0;
    return {neg, EXP_W'(11'd1023 + {6'd0, msb}), nm[30:0], 21'd0};
  endfunction

endpackage

/* hw/rtl/double_int32_bitwise_alu_unit.sv */
// Top level: input register, datapath, output register with stream handshakes.
// Path: an item passes the input register and then the result register between input transfer and result transfer.
// Throughput: one item per cycle; the result register drains while the next
// item is taken, so both stages advance together whenever the output moves.
// Reset: rst_n synchronous active low clears both valid flags; payload not reset.
module double_int32_bitwise_alu_unit
  import dib_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [135:0] in_tdata,   // [2:0] op, [66:3] a_bits, [130:67] b_bits, rest 0
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata    // [63:0] result_bits
);

  logic             s1_vld_r;
  logic [OP_W-1:0]  op_r;
  logic [DBL_W-1:0] a_r;
  logic [DBL_W-1:0] b_r;
  logic [DBL_W-1:0] res;
  logic             out_vld_r;
  logic [DBL_W-1:0] out_r;
  logic             adv_out;
  logic             adv_in;

  assign adv_out   = ~out_vld_r | out_tready;
  assign adv_in    = ~s1_vld_r | adv_out;
  assign in_tready = adv_in;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv_in) begin
      s1_vld_r <= in_tvalid;
    end
    if (adv_in && in_tvalid) begin
      op_r <= in_tdata[2:0];
      a_r  <= in_tdata[66:3];
      b_r  <= in_tdata[130:67];
    end
  end

  dib_core u_core (
    .op          (op_r),
    .a_bits      (a_r),
    .b_bits      (b_r),
    .result_bits (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv_out) begin
      out_vld_r <= s1_vld_r;
    end
    if (adv_out && s1_vld_r) out_r <= res;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_r;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");
  a_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && adv_out |=> out_vld_r)
    else $error("staged item lost");
  a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_vld_r |-> in_tready)
    else $error("empty stage not ready");

endmodule

/* hw/rtl/dib_core.sv */
// Combinational datapath: operand conversion, logic/shift op, result to binary64.
module dib_core
  import dib_pkg::*;
(
  input  logic [OP_W-1:0]  op,
  input  logic [DBL_W-1:0] a_bits,
  input  logic [DBL_W-1:0] b_bits,
  output logic [DBL_W-1:0] result_bits
);

  logic [INT_W-1:0] a;
  logic [INT_W-1:0] b;
  logic [4:0]       n;
  logic [INT_W-1:0] r;

  assign a = to_u32(a_bits);
  assign b = to_u32(b_bits);
  assign n = b[4:0];

  // operation select and conversion back
  always_comb begin
    r = '0;
    result_bits = '0;
    case (op_t'(op))
      OP_AND: r = a & b;
      OP_OR:  r = a | b;
      OP_XOR: r = a ^ b;
      OP_NOT: r = ~a;
      OP_SHL: r = a << n;
      OP_SAR: r = INT_W'($signed(a) >>> n);
      OP_SHR: r = a >> n;
      default: r = '0;
    endcase
    if (op_t'(op) != OP_NOP) result_bits = to_dbl(r, op_t'(op) == OP_SHR);
  end

endmodule

/* tb/testbench.sv */
// Testbench for the int32 bitwise ALU on binary64 operands: random and directed stream traffic.
`timescale 1ns / 1ps

module testbench
  import dib_pkg::*;
;

  typedef struct packed {
    logic [63:0] b_bits;
    logic [63:0] a_bits;
    op_t         op;
  } alu_req_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [135:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [63:0]  out_tdata;

  double_int32_bitwise_alu_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  alu_req_t    pending_reqs[$];
  logic [63:0] expected_results[$];
  int          send_idle_pct;
  int          recv_idle_pct;
  int          recv_hold;
  bit          hold_req;
  bit          hold_taken;
  bit          stim_done;
  int          err_count = 0;
  int          op_seen[8] = '{default: 0};
  int          results_checked = 0;
  int          quiet_cycles = 0;

  localparam int QUIET_LIMIT = 5000;
  localparam int LONG_HOLD   = 200;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ToUint32 of a binary64 pattern
  function automatic logic [31:0] dbl_to_u32(input logic [63:0] bits);
    int unsigned ex;
    logic [52:0] mant;
    logic [31:0] v;
    ex   = bits[62:52];
    mant = {1'b1, bits[51:0]};
    if (ex == 2047 || ex < 1023) return 32'd0;
    if (ex >= 1075) begin
      if (ex - 1075 >= 32) return 32'd0;
      v = 32'(mant << (ex - 1075));
    end else begin
      v = 32'(mant >> (1075 - ex));
    end
    if (bits[63]) v = -v;
    return v;
  endfunction

  // Exact double of a 32-bit integer via real conversion
  function automatic logic [63:0] int_to_dbl_bits(input logic [31:0] r, input bit uns);
    real d;
    if (r == 32'd0) return 64'd0;
    if (uns) d = real'(longint'({32'd0, r}));
    else     d = real'(longint'(signed'(r)));
    return $realtobits(d);
  endfunction

  function automatic logic [63:0] alu_result(input alu_req_t q);
    logic [31:0] a, b, r;
    logic [4:0]  n;
    a = dbl_to_u32(q.a_bits);
    b = dbl_to_u32(q.b_bits);
    n = b[4:0];
    case (q.op)
      OP_AND: r = a & b;
      OP_OR:  r = a | b;
      OP_XOR: r = a ^ b;
      OP_NOT: r = ~a;
      OP_SHL: r = a << n;
      OP_SAR: r = 32'($signed(a) >>> n);
      OP_SHR: return int_to_dbl_bits(a >> n, 1'b1);
      default: return 64'd0;
    endcase
    return int_to_dbl_bits(r, 1'b0);
  endfunction

  // Random double biased toward the integer range and special encodings
  function automatic logic [63:0] rand_dbl();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: v[62:52] = 11'h7FF;
      1: v[62:52] = 11'(1075 + $urandom_range(0, 40));
      2: v[62:52] = 11'($urandom_range(0, 1023));
      3, 4: ;
      default: v[62:52] = 11'(1023 + $urandom_range(0, 52));
    endcase
    return v;
  endfunction

  task automatic add_req(input op_t op, input logic [63:0] a, input logic [63:0] b);
    alu_req_t q;
    q.op = op; q.a_bits = a; q.b_bits = b;
    pending_reqs.push_back(q);
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || expected_results.size() != 0) @(posedge clk);
  endtask

  // Stimulus
  initial begin
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req      = 1'b0;
    stim_done     = 1'b0;
    rst_n         = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: every op, NaN, infinities, signed zero, subnormal, huge, wrap cases
    for (int o = 0; o < 8; o++)
      add_req(op_t'(o), 64'hC1E0_0000_0000_0000, 64'h4014_0000_0000_0000);
    add_req(OP_OR,  64'h7FF8_0000_0000_0001, 64'h7FF0_0000_0000_0000);
    add_req(OP_XOR, 64'hFFF0_0000_0000_0000, 64'h8000_0000_0000_0000);
    add_req(OP_OR,  64'h0000_0000_0000_0001, 64'h3FEF_FFFF_FFFF_FFFF);
    add_req(OP_OR,  64'h41F0_0000_0000_0000, 64'h7FEF_FFFF_FFFF_FFFF);
    add_req(OP_NOT, 64'hC1EF_FFFF_FFE0_0000, 64'hFFFF_FFFF_FFFF_FFFF);
    add_req(OP_SHL, 64'h3FF0_0000_0000_0000, 64'h403F_0000_0000_0000);
    add_req(OP_SHL, 64'h41DF_FFFF_FFC0_0000, 64'h3FF0_0000_0000_0000);
    add_req(OP_SAR, 64'hBFF0_0000_0000_0000, 64'h4040_0000_0000_0000);
    add_req(OP_SHR, 64'hBFF0_0000_0000_0000, 64'h0000_0000_0000_0000);
    add_req(OP_SHR, 64'hBFF0_0000_0000_0000, 64'h403F_0000_0000_0000);
    add_req(OP_AND, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    add_req(OP_AND, 64'h0000_0000_0000_0000, 64'h0000_0000_0000_0000);
    add_req(OP_XOR, 64'h4330_0000_0000_0001, 64'hC330_0000_0000_0001);
    add_req(OP_SAR, 64'h433F_FFFF_FFFF_FFFF, 64'h3FFF_FFFF_FFFF_FFFF);
    add_req(OP_NOT, 64'h434F_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0000);
    wait_drained();

    // three idle profiles, random traffic
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 19 : (phase == 1) ? 72 : 0;
      recv_idle_pct = (phase == 0) ? 72 : (phase == 1) ? 19 : 0;
      for (int i = 0; i < 510; i++) begin
        add_req(op_t'($urandom_range(0, 7)), rand_dbl(), rand_dbl());
        if (phase == 2 && i == 100) hold_req = 1'b1;
        if (pending_reqs.size() > 40) wait_drained();
      end
      // sender pauses until the pipe is empty
      wait_drained();
    end
    repeat (10) @(posedge clk);
    stim_done = 1'b1;
  end

  // Driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) begin
        expected_results.push_back(alu_result(pending_reqs[0]));
        op_seen[pending_reqs[0].op]++;
        void'(pending_reqs.pop_front());
      end
      if (pending_reqs.size() > (in_tvalid ? 1 : 0) - (in_tvalid ? 1 : 0)
          && pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata  <= {5'd0, pending_reqs[0]};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver ready with random stalls and one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      recv_hold  <= 0;
      hold_taken <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      recv_hold  <= LONG_HOLD - 1;
      out_tready <= 1'b0;
    end else if (recv_hold > 0) begin
      recv_hold  <= recv_hold - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Monitor and checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result transfer, expected none, actual %h",
                 $time, out_tdata);
        err_count++;
      end else begin
        if (out_tdata !== expected_results[0]) begin
          $display("%0t: result_bits mismatch, expected %h, actual %h",
                   $time, expected_results[0], out_tdata);
          err_count++;
        end
        void'(expected_results.pop_front());
        results_checked++;
      end
    end
  end

  // Watchdog and end of run
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT && !stim_done) begin
      $display("%0t: timeout, %0d results outstanding", $time, expected_results.size());
      $display("double_int32_bitwise_alu_unit regression: fail");
      $finish;
    end else if (stim_done) begin
      $display("Checked %0d results over all eight opcodes (and %0d, shl %0d, nop %0d),",
               results_checked, op_seen[0], op_seen[4], op_seen[7]);
      $display("with NaN/inf/huge/subnormal operands, three stall profiles and a long hold-off.");
      if (err_count == 0 && expected_results.size() == 0)
        $display("double_int32_bitwise_alu_unit regression: pass");
      else
        $display("double_int32_bitwise_alu_unit regression: fail");
      $finish;
    end
  end

endmodule

/* sim.f */
hw/rtl/dib_pkg.sv
hw/rtl/dib_core.sv
hw/rtl/double_int32_bitwise_alu_unit.sv
tb/testbench.sv
